// ===== rtl/slnt_pkg.sv =====
package slnt_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int KEY_W           = 16;
  localparam int PAY_W           = 16;
  localparam int ENTRY_W         = KEY_W + PAY_W;

  typedef enum logic [2:0] {
    MODE_INSERT = 3'd0,
    MODE_DELETE = 3'd1,
    MODE_FIND   = 3'd2,
    MODE_LOWER  = 3'd3,
    MODE_READ   = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_BAD_INDEX = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_UP,
    S_PUT,
    S_DOWN,
    S_READ,
    S_DONE
  } state_t;

endpackage

// ===== rtl/slnt_req_if.sv =====
interface slnt_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [15:0] line_key;
  logic [15:0] entry_payload;
  logic [5:0]  entry_index;

  modport source (output valid, mode, line_key, entry_payload, entry_index, input ready);
  modport sink   (input valid, mode, line_key, entry_payload, entry_index, output ready);
endinterface

// ===== rtl/slnt_rsp_if.sv =====
interface slnt_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [6:0]  result_index;
  logic [15:0] result_key;
  logic [15:0] result_payload;
  logic [6:0]  entry_count;

  modport source (output valid, status, result_index, result_key, result_payload, entry_count,
                  input ready);
  modport sink   (input valid, status, result_index, result_key, result_payload, entry_count,
                  output ready);
endinterface

// ===== rtl/sorted_line_number_table_top.sv =====
// Handles one request at a time; the next request is taken once the result has been
// registered, which waits while an earlier result is still unaccepted. Cost is set by
// the table walk, one entry per cycle.
// Reset (synchronous, rst high) empties the table; stored entries are not cleared.
module sorted_line_number_table_top #(
  parameter int TABLE_DEPTH = slnt_pkg::TABLE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  slnt_req_if.sink   req,
  slnt_rsp_if.source rsp
);
  import slnt_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [AW-1:0]      mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;

  slnt_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  slnt_ctrl #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

endmodule

// ===== rtl/slnt_mem.sv =====
module slnt_mem #(
  parameter int DEPTH = slnt_pkg::TABLE_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [slnt_pkg::ENTRY_W-1:0] wdata,
  input  logic [AW-1:0]              raddr,
  output logic [slnt_pkg::ENTRY_W-1:0] rdata
);
  import slnt_pkg::*;

  logic [ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/slnt_ctrl.sv =====
module slnt_ctrl #(
  parameter int DEPTH = slnt_pkg::TABLE_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         rst,
  slnt_req_if.sink                     req,
  slnt_rsp_if.source                   rsp,
  output logic                         mem_we,
  output logic [AW-1:0]                mem_waddr,
  output logic [slnt_pkg::ENTRY_W-1:0] mem_wdata,
  output logic [AW-1:0]                mem_raddr,
  input  logic [slnt_pkg::ENTRY_W-1:0] mem_rdata
);
  import slnt_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  state_t           state, state_next;
  logic [CW-1:0]    count, count_next;
  logic [CW-1:0]    ptr, ptr_next;
  logic [CW-1:0]    pos, pos_next;
  logic [2:0]       mode_r, mode_next;
  logic [KEY_W-1:0] key_r, key_next;
  logic [PAY_W-1:0] pay_r, pay_next;

  status_t          res_status, res_status_next;
  logic [CW-1:0]    res_index, res_index_next;
  logic [KEY_W-1:0] res_key, res_key_next;
  logic [PAY_W-1:0] res_pay, res_pay_next;

  logic             out_valid, out_valid_next;
  status_t          out_status, out_status_next;
  logic [6:0]       out_index, out_index_next;
  logic [KEY_W-1:0] out_key, out_key_next;
  logic [PAY_W-1:0] out_pay, out_pay_next;
  logic [6:0]       out_count, out_count_next;

  logic [KEY_W-1:0] rd_key;
  logic             idx_bad;
  logic             hit;

  assign rd_key  = mem_rdata[ENTRY_W-1:PAY_W];
  assign idx_bad = 32'(req.entry_index) >= 32'(count);
  assign hit     = (mode_r == MODE_FIND) ? (rd_key == key_r) : (rd_key >= key_r);

  assign req.ready          = (state == S_IDLE);
  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.result_index   = out_index;
  assign rsp.result_key     = out_key;
  assign rsp.result_payload = out_pay;
  assign rsp.entry_count    = out_count;

  always_comb begin
    state_next      = state;
    count_next      = count;
    ptr_next        = ptr;
    pos_next        = pos;
    mode_next       = mode_r;
    key_next        = key_r;
    pay_next        = pay_r;
    res_status_next = res_status;
    res_index_next  = res_index;
    res_key_next    = res_key;
    res_pay_next    = res_pay;
    out_valid_next  = out_valid & ~rsp.ready;
    out_status_next = out_status;
    out_index_next  = out_index;
    out_key_next    = out_key;
    out_pay_next    = out_pay;
    out_count_next  = out_count;
    mem_we          = 1'b0;
    mem_waddr       = AW'(ptr);
    mem_wdata       = mem_rdata;
    mem_raddr       = '0;

    case (state)
      S_IDLE: begin
        // read issued now so data is ready on the first working cycle
        mem_raddr = AW'(req.entry_index);
        if (req.valid) begin
          mode_next       = req.mode;
          key_next        = req.line_key;
          pay_next        = req.entry_payload;
          ptr_next        = '0;
          res_status_next = STAT_OK;
          res_index_next  = '0;
          res_key_next    = '0;
          res_pay_next    = '0;
          case (req.mode)
            MODE_INSERT: begin
              mem_raddr = '0;
              if (count == CW'(DEPTH)) begin
                res_status_next = STAT_FULL;
                state_next      = S_DONE;
              end else begin
                state_next = S_SCAN;
              end
            end
            MODE_DELETE: begin
              if (idx_bad) begin
                res_status_next = STAT_BAD_INDEX;
                state_next      = S_DONE;
              end else begin
                ptr_next   = CW'(req.entry_index);
                mem_raddr  = AW'(CW'(req.entry_index) + CW'(1));
                state_next = S_DOWN;
              end
            end
            MODE_FIND, MODE_LOWER: begin
              mem_raddr  = '0;
              state_next = S_SCAN;
            end
            MODE_READ: begin
              if (idx_bad) begin
                res_status_next = STAT_BAD_INDEX;
                state_next      = S_DONE;
              end else begin
                state_next = S_READ;
              end
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        // data in hand is entry ptr; fetch ptr+1 speculatively
        mem_raddr = AW'(ptr + CW'(1));
        if (ptr == count || hit) begin
          case (mode_r)
            MODE_FIND: begin
              if (ptr == count) begin
                res_status_next = STAT_NOT_FOUND;
              end else begin
                res_index_next = ptr;
              end
              state_next = S_DONE;
            end
            MODE_LOWER: begin
              res_index_next = ptr;
              state_next     = S_DONE;
            end
            default: begin
              pos_next       = ptr;
              res_index_next = ptr;
              ptr_next       = count;
              mem_raddr      = AW'(count - CW'(1));
              state_next     = S_UP;
            end
          endcase
        end else begin
          ptr_next = ptr + CW'(1);
        end
      end

      S_UP: begin
        // ptr is the slot to fill; entry ptr-1 is in hand, ptr-2 fetched next
        if (ptr > pos) begin
          mem_we     = 1'b1;
          mem_raddr  = AW'(ptr - CW'(2));
          ptr_next   = ptr - CW'(1);
        end else begin
          state_next = S_PUT;
        end
      end

      S_PUT: begin
        mem_we     = 1'b1;
        mem_waddr  = AW'(pos);
        mem_wdata  = {key_r, pay_r};
        count_next = count + CW'(1);
        state_next = S_DONE;
      end

      S_DOWN: begin
        // ptr is the slot to fill; entry ptr+1 is in hand, ptr+2 fetched next
        if (ptr + CW'(1) < count) begin
          mem_we       = 1'b1;
          mem_raddr    = AW'(ptr + CW'(2));
          ptr_next     = ptr + CW'(1);
        end else begin
          count_next = count - CW'(1);
          state_next = S_DONE;
        end
      end

      S_READ: begin
        res_key_next = rd_key;
        res_pay_next = mem_rdata[PAY_W-1:0];
        state_next   = S_DONE;
      end

      S_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next  = 1'b1;
          out_status_next = res_status;
          out_index_next  = 7'(res_index);
          out_key_next    = res_key;
          out_pay_next    = res_pay;
          out_count_next  = 7'(count);
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr        <= ptr_next;
    pos        <= pos_next;
    mode_r     <= mode_next;
    key_r      <= key_next;
    pay_r      <= pay_next;
    res_status <= res_status_next;
    res_index  <= res_index_next;
    res_key    <= res_key_next;
    res_pay    <= res_pay_next;
    out_status <= out_status_next;
    out_index  <= out_index_next;
    out_key    <= out_key_next;
    out_pay    <= out_pay_next;
    out_count  <= out_count_next;
  end

endmodule
